// ----- src/uer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Types, register indexes and arithmetic helpers for the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int unsigned TickW   = 16;
	localparam int unsigned DistW   = 11;
	localparam int unsigned SumW    = 12;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [TickW-1:0] TrigLowTicks  = 16'd2;
	localparam logic [TickW-1:0] TrigHighTicks = 16'd10;
	localparam logic [1:0]       ReadingsAvg   = 2'd3;

	// floor(t*17/1000) == (t * 17 * ceil(2^30/1000)) >> 30 for t <= 65536
	localparam logic [24:0] DistMul   = 25'd18253614;
	localparam int unsigned DistShift = 30;
	// floor(s/3) == (s * ceil(2^13/3)) >> 13 for s < 4096
	localparam logic [11:0] Div3Mul   = 12'd2731;
	localparam int unsigned Div3Shift = 13;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ECHO_WAIT_LIMIT = 2'd0,
		REG_PULSE_LIMIT     = 2'd1,
		REG_AVERAGE_THREE   = 2'd2,
		REG_SETTLE_GAP      = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LOW    = 3'd1,
		PH_HIGH   = 3'd2,
		PH_WAIT   = 3'd3,
		PH_MEAS   = 3'd4,
		PH_SETTLE = 3'd5
	} phase_t;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} in_t;

	typedef struct packed {
		logic             trig_level;
		logic             busy_res;
		logic             done_res;
		logic [DistW-1:0] distance_cm;
		logic             timed_out;
	} out_t;

	// Echo-high tick count to centimeters.
	function automatic logic [DistW-1:0] ticks_to_cm(input logic [TickW:0] ticks);
		logic [41:0] prod;
		prod = {25'd0, ticks} * {17'd0, DistMul};
		return prod[DistShift +: DistW];
	endfunction

	function automatic logic [DistW-1:0] div3(input logic [SumW-1:0] s);
		logic [23:0] prod;
		prod = {12'd0, s} * {12'd0, Div3Mul};
		return prod[Div3Shift +: DistW];
	endfunction

endpackage

// ----- src/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger/echo sequencer for an ultrasonic range sensor, one item per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one microsecond tick carrying a start request and
// the sampled echo level; each one yields exactly one output transaction with
// the trigger level for that tick, busy/done flags and, on the done tick, the
// distance in cm and the timeout flag.
// Channels: in_valid/in_ready and out_valid/out_ready, payloads as uer_pkg
// structs. Config writes (cfg_we, cfg_index, cfg_wdata) are registered directly.
// Pipeline: stage one runs the sequencer and the tick-to-cm multiply, stage two
// the divide by three; each stage registers its result.
// Throughput: one item per cycle while out_ready stays high.
// Stall: with out_ready low the two-stage output pipe fills, then in_ready
// drops; no transaction is lost or repeated.
// Reset: sequencer idle, counters cleared, registers at their defaults
// (wait limit 60000, pulse limit 60000, single reading, settle gap 1000).
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  uer_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output uer_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [uer_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [uer_pkg::TickW-1:0]       cfg_wdata
);
	import uer_pkg::*;

	typedef struct packed {
		logic            trig_level;
		logic            busy_res;
		logic            done_res;
		logic            avg;
		logic [SumW-1:0] value;
		logic            timed_out;
	} mid_t;

	logic [TickW-1:0] echo_wait_limit_q;
	logic [TickW-1:0] pulse_limit_q;
	logic             average_three_q;
	logic [TickW-1:0] settle_gap_q;

	phase_t           phase_q, phase_d;
	logic [TickW-1:0] tick_q, tick_d;
	logic [1:0]       idx_q, idx_d;
	logic [SumW-1:0]  sum_q, sum_d;
	logic             any_to_q, any_to_d;

	logic             v_s1, v_s2;
	mid_t             mid_s1, mid_d;
	out_t             out_s2;
	logic             en1, en2;

	logic [TickW:0]   tick_inc;
	logic             fin;
	logic             fin_to;
	logic [TickW:0]   fin_ticks;
	logic [DistW-1:0] reading_cm;
	logic [SumW-1:0]  sum_new;
	logic [1:0]       idx_new;
	logic             seq_done;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_wait_limit_q <= 16'd60000;
			pulse_limit_q     <= 16'd60000;
			average_three_q   <= 1'b0;
			settle_gap_q      <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ECHO_WAIT_LIMIT: echo_wait_limit_q <= cfg_wdata;
				REG_PULSE_LIMIT:     pulse_limit_q     <= cfg_wdata;
				REG_AVERAGE_THREE:   average_three_q   <= cfg_wdata[0];
				REG_SETTLE_GAP:      settle_gap_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign tick_inc = {1'b0, tick_q} + {{TickW{1'b0}}, 1'b1};

	// sequencer next state
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		idx_d     = idx_q;
		sum_d     = sum_q;
		any_to_d  = any_to_q;
		fin       = 1'b0;
		fin_to    = 1'b0;
		fin_ticks = '0;
		mid_d     = '0;
		case (phase_q)
			PH_IDLE: begin
				if (in_data.start_req) begin
					idx_d    = '0;
					sum_d    = '0;
					any_to_d = 1'b0;
					tick_d   = {{(TickW-1){1'b0}}, 1'b1};
					phase_d  = PH_LOW;
				end
			end
			PH_LOW: begin
				if (tick_inc >= {1'b0, TrigLowTicks}) begin
					tick_d  = '0;
					phase_d = PH_HIGH;
				end else begin
					tick_d = tick_inc[TickW-1:0];
				end
			end
			PH_HIGH: begin
				mid_d.trig_level = 1'b1;
				if (tick_inc >= {1'b0, TrigHighTicks}) begin
					tick_d  = '0;
					phase_d = PH_WAIT;
				end else begin
					tick_d = tick_inc[TickW-1:0];
				end
			end
			PH_WAIT: begin
				if (in_data.echo_level) begin
					tick_d = {{(TickW-1){1'b0}}, 1'b1};
					if (pulse_limit_q <= {{(TickW-1){1'b0}}, 1'b1}) begin
						fin       = 1'b1;
						fin_ticks = {{TickW{1'b0}}, 1'b1};
					end else begin
						phase_d = PH_MEAS;
					end
				end else if (tick_inc >= {1'b0, echo_wait_limit_q}) begin
					fin    = 1'b1;
					fin_to = 1'b1;
				end else begin
					tick_d = tick_inc[TickW-1:0];
				end
			end
			PH_MEAS: begin
				if (in_data.echo_level) begin
					if (tick_inc >= {1'b0, pulse_limit_q}) begin
						fin       = 1'b1;
						fin_ticks = tick_inc;
					end else begin
						tick_d = tick_inc[TickW-1:0];
					end
				end else begin
					fin       = 1'b1;
					fin_ticks = {1'b0, tick_q};
				end
			end
			PH_SETTLE: begin
				if (tick_q >= settle_gap_q) begin
					tick_d  = {{(TickW-1){1'b0}}, 1'b1};
					phase_d = PH_LOW;
				end else begin
					tick_d = tick_inc[TickW-1:0];
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = '0;
			end
		endcase

		// close out one reading
		reading_cm = fin_to ? '0 : ticks_to_cm(fin_ticks);
		sum_new    = sum_q + {1'b0, reading_cm};
		idx_new    = idx_q + 2'd1;
		seq_done   = !average_three_q || (idx_new >= ReadingsAvg);
		if (fin) begin
			tick_d   = '0;
			sum_d    = sum_new;
			idx_d    = idx_new;
			any_to_d = any_to_q | fin_to;
			phase_d  = seq_done ? PH_IDLE : PH_SETTLE;
			if (seq_done) begin
				mid_d.done_res  = 1'b1;
				mid_d.avg       = average_three_q;
				mid_d.value     = average_three_q ? sum_new : {1'b0, reading_cm};
				mid_d.timed_out = any_to_q | fin_to;
			end
		end
		mid_d.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			idx_q    <= '0;
			sum_q    <= '0;
			any_to_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
				if (in_valid) begin
					phase_q  <= phase_d;
					tick_q   <= tick_d;
					idx_q    <= idx_d;
					sum_q    <= sum_d;
					any_to_q <= any_to_d;
				end
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			mid_s1 <= mid_d;
		end
		if (en2 && v_s1) begin
			out_s2.trig_level  <= mid_s1.trig_level;
			out_s2.busy_res    <= mid_s1.busy_res;
			out_s2.done_res    <= mid_s1.done_res;
			out_s2.timed_out   <= mid_s1.timed_out;
			out_s2.distance_cm <= mid_s1.avg ? div3(mid_s1.value)
			                                 : mid_s1.value[DistW-1:0];
		end
	end

	assign out_valid = v_s2;
	assign out_data  = out_s2;

endmodule
